### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the ethertype restore checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define CHK_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define CHK_SAME(lbl, clk, rst_n, ante, cons)
`define CHK_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### rtl/ipv4_erc_pkg.sv
// Package: constants and verdict codes of the ethertype restore checker.
`timescale 1ns / 1ps
`default_nettype none

package ipv4_erc_pkg;

    localparam int CountBits = 17;
    localparam int LenBits   = CountBits + 1;

    localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

    localparam logic [15:0] DefaultFakeType = 16'h88B5;
    localparam logic [15:0] TypeIpv4        = 16'h0800;
    localparam logic [15:0] TypeVlan        = 16'h8100;
    localparam logic [16:0] SumAllOnes      = 17'h0FFFF;

    localparam logic [CountBits-1:0] PosTypeHi  = CountBits'(12);
    localparam logic [CountBits-1:0] PosTypeLo  = CountBits'(13);
    localparam logic [CountBits-1:0] PosVerIhl  = CountBits'(14);
    localparam logic [CountBits-1:0] PosTotHi   = CountBits'(16);
    localparam logic [CountBits-1:0] PosTotLo   = CountBits'(17);

    localparam logic [LenBits-1:0] MinFrameLen = LenBits'(34);
    localparam logic [LenBits-1:0] EthHdrLen   = LenBits'(14);
    localparam logic [5:0]         MinIhl      = 6'd20;
    localparam logic [5:0]         MaxIhl      = 6'd60;
    localparam logic [3:0]         IpVersion4  = 4'd4;

    typedef logic [2:0] t_verdict;

    localparam t_verdict VerdictRestore  = 3'd0;
    localparam t_verdict VerdictShort    = 3'd1;
    localparam t_verdict VerdictKnown    = 3'd2;
    localparam t_verdict VerdictNotV4    = 3'd3;
    localparam t_verdict VerdictBadIhl   = 3'd4;
    localparam t_verdict VerdictBadTotal = 3'd5;
    localparam t_verdict VerdictBadSum   = 3'd6;
    localparam t_verdict VerdictMismatch = 3'd7;

    localparam logic RegFakeType = 1'b0;

endpackage

`default_nettype wire

### rtl/ipv4_ethertype_restore_check_top.sv
// Top level: byte-stream IPv4 ethertype restore checker with APB register.
//
// Channel   Dir  Beat content
// s_axis    in   tdata[7:0] frame_byte, tlast end_of_frame
// m_axis    out  tdata[0] restore_type, tdata[3:1] verdict, tdata[7:4] zero
// apb       in   fake_ethertype at byte address 0
//
// One byte per cycle, sustained. A byte sits in the input register, then
// updates the frame state; the verdict of a last byte is registered into the
// output register as that byte leaves the input register. Reset is synchronous,
// active low, and clears the register and all frame state. A waiting verdict
// stalls the input only when the next last byte is ready to produce a new one.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ipv4_ethertype_restore_check_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] frame_byte
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [0] restore_type, [3:1] verdict, [7:4] zero
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import ipv4_erc_pkg::*;

    logic [15:0]          r_fake;
    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_in_last;
    logic [CountBits-1:0] r_count;
    logic [15:0]          r_type;
    logic [7:0]           r_ver_ihl;
    logic [15:0]          r_total;
    logic [20:0]          r_sum;
    logic [7:0]           r_hold;
    logic                 r_out_valid;
    logic                 r_out_restore;
    t_verdict             r_out_verdict;

    logic                 s_accept;
    logic                 advance;
    logic [CountBits-1:0] n_count;
    logic [15:0]          n_type;
    logic [7:0]           n_ver_ihl;
    logic [15:0]          n_total;
    logic [20:0]          n_sum;
    logic [7:0]           n_hold;
    logic [5:0]           ihl;
    logic [LenBits-1:0]   pos_ext;
    logic [LenBits-1:0]   len;
    logic                 in_header;
    logic [16:0]          fold1;
    logic [16:0]          fold2;
    logic [7:0]           fake_hi;
    t_verdict             verdict;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == RegFakeType) ? {16'h0000, r_fake} : 32'h0000_0000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fake <= 16'h0000;
        end else if (psel && penable && pwrite && pready && (paddr[2] == RegFakeType)) begin
            r_fake <= pwdata[15:0];
        end
    end

    assign advance       = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    always_comb begin
        n_type    = r_type;
        n_ver_ihl = r_ver_ihl;
        n_total   = r_total;
        if (r_count == PosTypeHi) begin
            n_type[15:8] = r_in_byte;
        end else if (r_count == PosTypeLo) begin
            n_type[7:0] = r_in_byte;
        end else if (r_count == PosVerIhl) begin
            n_ver_ihl = r_in_byte;
        end else if (r_count == PosTotHi) begin
            n_total[15:8] = r_in_byte;
        end else if (r_count == PosTotLo) begin
            n_total[7:0] = r_in_byte;
        end

        ihl       = {n_ver_ihl[3:0], 2'b00};
        pos_ext   = {1'b0, r_count};
        in_header = (r_count >= PosVerIhl) && (pos_ext < EthHdrLen + LenBits'(ihl));

        n_hold = r_hold;
        n_sum  = r_sum;
        if (in_header) begin
            if (!r_count[0]) begin
                n_hold = r_in_byte;
            end else begin
                n_sum = r_sum + {5'b00000, r_hold, r_in_byte};
            end
        end

        n_count = (r_count == CountMax) ? r_count : r_count + CountBits'(1);
    end

    always_comb begin
        len     = pos_ext + LenBits'(1);
        fold1   = {1'b0, n_sum[15:0]} + {12'h000, n_sum[20:16]};
        fold2   = {1'b0, fold1[15:0]} + {16'h0000, fold1[16]};
        fake_hi = (r_fake == 16'h0000) ? DefaultFakeType[15:8] : r_fake[15:8];

        if (len < MinFrameLen) begin
            verdict = VerdictShort;
        end else if (n_type == TypeIpv4 || n_type == TypeVlan) begin
            verdict = VerdictKnown;
        end else if (n_ver_ihl[7:4] != IpVersion4) begin
            verdict = VerdictNotV4;
        end else if (ihl < MinIhl || ihl > MaxIhl || len < EthHdrLen + LenBits'(ihl)) begin
            verdict = VerdictBadIhl;
        end else if (n_total < {10'h000, ihl} || len < EthHdrLen + LenBits'(n_total)) begin
            verdict = VerdictBadTotal;
        end else if (fold2 != SumAllOnes) begin
            verdict = VerdictBadSum;
        end else if (n_type[15:8] != fake_hi) begin
            verdict = VerdictMismatch;
        end else begin
            verdict = VerdictRestore;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_type    <= 16'h0000;
            r_ver_ihl <= 8'h00;
            r_total   <= 16'h0000;
            r_sum     <= 21'h000000;
            r_hold    <= 8'h00;
        end else if (advance) begin
            if (r_in_last) begin
                r_count   <= '0;
                r_type    <= 16'h0000;
                r_ver_ihl <= 8'h00;
                r_total   <= 16'h0000;
                r_sum     <= 21'h000000;
                r_hold    <= 8'h00;
            end else begin
                r_count   <= n_count;
                r_type    <= n_type;
                r_ver_ihl <= n_ver_ihl;
                r_total   <= n_total;
                r_sum     <= n_sum;
                r_hold    <= n_hold;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out_restore <= (verdict == VerdictRestore);
            r_out_verdict <= verdict;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'h0, r_out_verdict, r_out_restore};

    `CHK_SAME(a_restore_matches_verdict, i_clk, i_rst_n, r_out_valid,
              r_out_restore == (r_out_verdict == VerdictRestore))
    `CHK_NEXT(a_state_cleared_after_last, i_clk, i_rst_n, advance && r_in_last,
              r_count == '0 && r_sum == 21'h000000)
    `CHK_NEXT(a_count_advances, i_clk, i_rst_n,
              advance && !r_in_last && r_count != CountMax,
              r_count == $past(r_count) + CountBits'(1))
    `CHK_NEXT(a_verdict_not_lost, i_clk, i_rst_n, r_out_valid && !m_axis_tready,
              r_out_valid && $stable(r_out_verdict))

endmodule

`default_nettype wire
